// ===== hdl/mma_pkg.sv =====
`default_nettype none

package mma_pkg;

   // Field widths of the channels
   localparam int CHANNEL_W = 4;
   localparam int SAMPLE_W = 16;

   // Running sum width: sixteen full-scale samples still fit
   localparam int SUM_W = 20;

   // Default configuration
   localparam int CHANNELS_DEF = 8;
   localparam int WINDOW_DEF = 5;

   // Per-item tag that travels alongside the arithmetic
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                averaged;
      logic                bad_channel;
   } tag_type;

endpackage

`default_nettype wire

// ===== hdl/mma_req_if.sv =====
`default_nettype none

interface mma_req_if;
   logic                           valid;
   logic                           ready;
   logic [mma_pkg::CHANNEL_W-1:0]  channel;
   logic [mma_pkg::SAMPLE_W-1:0]   sample;

   modport source (output valid, output channel, output sample, input ready);
   modport sink (input valid, input channel, input sample, output ready);
endinterface

`default_nettype wire

// ===== hdl/mma_rsp_if.sv =====
`default_nettype none

interface mma_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mma_pkg::SAMPLE_W-1:0]  filtered;
   logic                          averaged;
   logic                          bad_channel;

   modport source (output valid, output filtered, output averaged, output bad_channel,
                   input ready);
   modport sink (input valid, input filtered, input averaged, input bad_channel,
                 output ready);
endinterface

`default_nettype wire

// ===== hdl/mma_div.sv =====
`default_nettype none

// Divide the window sum by WINDOW with a reciprocal multiply.
// With N = SUM_W and L = ceil(log2(WINDOW)), the multiplier ceil(2^(N+L)/WINDOW)
// gives the exact truncated quotient for every sum below 2^N.
module mma_div #(
   parameter int WINDOW = mma_pkg::WINDOW_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          load,
   input  wire logic [mma_pkg::SUM_W-1:0]     sum,
   output logic      [mma_pkg::SAMPLE_W-1:0]  quotient
);

   localparam int L_W = $clog2(WINDOW);
   localparam int SHIFT = mma_pkg::SUM_W + L_W;
   localparam int RECIP_W = mma_pkg::SUM_W + 1;
   localparam int PROD_W = mma_pkg::SUM_W + RECIP_W;
   localparam longint RECIP_L = ((longint'(1) << SHIFT) + longint'(WINDOW) - 1) / WINDOW;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

   logic [PROD_W-1:0] prod_ff;

   // Register the product
   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= PROD_W'(sum) * PROD_W'(RECIP);
      end
   end

   // Drop the fraction bits
   assign quotient = prod_ff[SHIFT +: mma_pkg::SAMPLE_W];

endmodule

`default_nettype wire

// ===== hdl/multichannel_moving_average.sv =====
`default_nettype none

// Per-channel boxcar moving average. Each item names a channel and carries a
// 16-bit sample; the result is the sample itself while that channel's window is
// still filling, and the truncated window average (sum / WINDOW) from the item
// that completes the window on, with averaged set. A channel at or above
// CHANNELS passes its sample through with bad_channel set and changes nothing.
// The block takes one item per clock cycle while results are taken; each result
// passes the stage 1, sum, product and output registers. The ring of samples
// and the running sums live in synchronous memories read at acceptance; the
// sum is updated in the stage after the read (forwarded when the same channel
// comes back to back) and divided by a registered reciprocal multiply. Fill
// counts and ring positions are held in flip-flops cleared by reset, so the
// block is ready in the first cycle after reset with no clearing pass.
module multichannel_moving_average #(
   parameter int CHANNELS = mma_pkg::CHANNELS_DEF,
   parameter int WINDOW = mma_pkg::WINDOW_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   mma_req_if.sink     req_chan,
   mma_rsp_if.source   rsp_chan
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int SLOT_W = $clog2(WINDOW);
   localparam int DEPTH = CHANNELS * WINDOW;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CMP_W = mma_pkg::CHANNEL_W + 1;
   localparam int SUM_W = mma_pkg::SUM_W;
   localparam int SAMPLE_W = mma_pkg::SAMPLE_W;

   // Pipeline enables, back to front
   logic en1, en2, en3, en4;
   logic req_fire;
   logic ch_good;
   logic [CH_W-1:0] ch_idx;

   // Per-channel fill count and oldest ring position
   logic [FILL_W-1:0] fill_ff [CHANNELS];
   logic [SLOT_W-1:0] slot_ff [CHANNELS];
   logic [FILL_W-1:0] fill_rd, fill_in;
   logic [SLOT_W-1:0] slot_rd, slot_in, slot_sel;
   logic              was_full, now_full;
   logic [ADDR_W-1:0] win_addr;

   // Ring and sum memories
   logic [SAMPLE_W-1:0] win_mem [DEPTH];
   logic [SUM_W-1:0]    sum_mem [CHANNELS];
   logic [SAMPLE_W-1:0] old_ff;
   logic [SUM_W-1:0]    sum_rd_ff;

   // Stage 1: memory data back, sum update
   logic                 s1_valid_ff;
   logic                 s1_good_ff;
   logic                 s1_first_ff;
   logic                 s1_sub_ff;
   logic [CH_W-1:0]      s1_ch_ff;
   mma_pkg::tag_type     s1_tag_ff;
   logic                 fwd_hit_ff;
   logic [SUM_W-1:0]     fwd_sum_ff;
   logic [SUM_W-1:0]     sum_base;
   logic [SUM_W-1:0]     sum_in;
   logic                 sum_we;

   // Stage 2: registered sum
   logic                 s2_valid_ff;
   mma_pkg::tag_type     s2_tag_ff;
   logic [SUM_W-1:0]     s2_sum_ff;

   // Stage 3: registered product
   logic                 s3_valid_ff;
   mma_pkg::tag_type     s3_tag_ff;
   logic [SAMPLE_W-1:0]  quotient;

   // Stage 4: output register
   logic                 out_valid_ff;
   logic [SAMPLE_W-1:0]  out_filtered_ff;
   logic                 out_averaged_ff;
   logic                 out_bad_ff;
   logic [SAMPLE_W-1:0]  out_filtered_in;

   // Advance each stage when the next one can take its item
   assign en4 = !out_valid_ff || rsp_chan.ready;
   assign en3 = !s3_valid_ff || en4;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;

   assign req_chan.ready = en1;
   assign req_fire = req_chan.valid && en1;

   // Decode the channel
   assign ch_good = {1'b0, req_chan.channel} < CMP_W'(CHANNELS);
   assign ch_idx = req_chan.channel[CH_W-1:0];

   // Look up ring position and form the ring address
   assign fill_rd = fill_ff[ch_idx];
   assign slot_rd = slot_ff[ch_idx];
   assign was_full = (fill_rd == FILL_W'(WINDOW));
   assign now_full = was_full || (fill_rd == FILL_W'(WINDOW - 1));
   assign slot_sel = was_full ? slot_rd : fill_rd[SLOT_W-1:0];
   assign win_addr = ADDR_W'(ch_idx) * ADDR_W'(WINDOW) + ADDR_W'(slot_sel);
   assign fill_in = fill_rd + 1'b1;
   assign slot_in = (slot_rd == SLOT_W'(WINDOW - 1)) ? '0 : slot_rd + 1'b1;

   // Advance fill count while filling, then the oldest position
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            fill_ff[i] <= '0;
            slot_ff[i] <= '0;
         end
      end else if (req_fire && ch_good) begin
         if (!was_full) begin
            fill_ff[ch_idx] <= fill_in;
         end else begin
            slot_ff[ch_idx] <= slot_in;
         end
      end
   end

   // Read the oldest sample and overwrite it in the same cycle
   always_ff @(posedge clock) begin
      if (req_fire && ch_good) begin
         old_ff <= win_mem[win_addr];
         win_mem[win_addr] <= req_chan.sample;
      end
   end

   // Read the channel sum at acceptance, write it back from stage 1
   always_ff @(posedge clock) begin
      if (req_fire && ch_good) begin
         sum_rd_ff <= sum_mem[ch_idx];
      end
      if (sum_we) begin
         sum_mem[s1_ch_ff] <= sum_in;
      end
   end

   // Stage 1 control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_hit_ff <= 1'b0;
      end else if (en1) begin
         s1_valid_ff <= req_chan.valid;
         fwd_hit_ff <= req_chan.valid && ch_good && s1_valid_ff && s1_good_ff &&
                       (s1_ch_ff == ch_idx);
      end
   end

   // Stage 1 payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_good_ff <= ch_good;
         s1_first_ff <= (fill_rd == '0);
         s1_sub_ff <= was_full;
         s1_ch_ff <= ch_idx;
         s1_tag_ff.sample <= req_chan.sample;
         s1_tag_ff.averaged <= ch_good && now_full;
         s1_tag_ff.bad_channel <= !ch_good;
      end
   end

   // Update the sum; take the previous item's result for the same channel
   assign sum_base = fwd_hit_ff ? fwd_sum_ff : (s1_first_ff ? '0 : sum_rd_ff);
   assign sum_in = sum_base + SUM_W'(s1_tag_ff.sample) - (s1_sub_ff ? SUM_W'(old_ff) : '0);
   assign sum_we = s1_valid_ff && s1_good_ff && en2;

   // Hold the last written sum for forwarding
   always_ff @(posedge clock) begin
      if (sum_we) begin
         fwd_sum_ff <= sum_in;
      end
   end

   // Stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_tag_ff <= s1_tag_ff;
         s2_sum_ff <= sum_in;
      end
   end

   // Stage 3: divide by the window length
   mma_div #(
      .WINDOW (WINDOW)
   ) u_div (
      .clock    (clock),
      .load     (en3),
      .sum      (s2_sum_ff),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en3) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_tag_ff <= s2_tag_ff;
      end
   end

   // Stage 4: select average or raw sample into the output register
   assign out_filtered_in = s3_tag_ff.averaged ? quotient : s3_tag_ff.sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en4) begin
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         out_filtered_ff <= out_filtered_in;
         out_averaged_ff <= s3_tag_ff.averaged;
         out_bad_ff <= s3_tag_ff.bad_channel;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.filtered = out_filtered_ff;
   assign rsp_chan.averaged = out_averaged_ff;
   assign rsp_chan.bad_channel = out_bad_ff;

`ifndef NO_ASSERTIONS
   // Forwarding only ever comes from a valid in-range item in stage 1
   a_fwd_source: assert property (@(posedge clock) disable iff (reset)
      fwd_hit_ff |-> (s1_valid_ff && s1_good_ff))
      else $error("forwarding hit without an in-range stage 1 item");

   // An accepted item always lands in stage 1
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted item lost before stage 1");

   // Fill count saturates at the window length
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (req_fire && ch_good) |-> (fill_rd <= FILL_W'(WINDOW)))
      else $error("fill count beyond window length");

   // The oldest position only moves once the window is full
   a_slot_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && ch_good && !was_full) |-> (slot_rd == '0))
      else $error("ring position moved while filling");

   // An out-of-range item never carries an average
   a_bad_raw: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_averaged_ff && out_bad_ff))
      else $error("average reported for a bad channel");
`endif

endmodule

`default_nettype wire
